### src/dhkt_pkg.sv
// Shared types, codes and constants of the double hashing key table.
package dhkt_pkg;

    localparam int KEY_W      = 64;
    localparam int SIZE_W     = 11;
    localparam int SLOT_W     = 10;
    localparam int STATUS_W   = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int NUM_SIZES  = 4;
    localparam int SIZE_RESET = 1024;
    localparam int DIV_BITS   = 4;
    localparam int DIV_STEPS  = KEY_W / DIV_BITS;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

    typedef logic [STATUS_W-1:0] t_status;

    localparam t_status ST_FOUND     = 3'd0;
    localparam t_status ST_NOT_FOUND = 3'd1;
    localparam t_status ST_INSERTED  = 3'd2;
    localparam t_status ST_PRESENT   = 3'd3;
    localparam t_status ST_FULL      = 3'd4;

    localparam logic ACT_FIND   = 1'b0;
    localparam logic ACT_INSERT = 1'b1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic    clr_step;
        logic    load;
        logic    div_step;
        logic    probe_init;
        logic    rd;
        logic    advance;
        logic    wr;
        logic    res_set;
        logic    res_slot;
        t_status res_code;
        logic    out_load;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clr_last;
        logic div_last;
        logic tbl_ok;
        logic act;
        logic hit;
        logic empty;
        logic last_probe;
        logic out_free;
    } t_sts;

endpackage

### src/dhkt_ram.sv
// Generic single-port RAM with a registered read.
module dhkt_ram #(
    parameter int WIDTH = 65,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port share one address.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### src/dhkt_rem.sv
// Remainder unit: restoring division, four dividend bits per cycle in which i_step is high.
module dhkt_rem (
    input  logic                          i_clk,
    input  logic                          i_load,
    input  logic                          i_step,
    input  logic [dhkt_pkg::KEY_W-1:0]    i_dividend,
    input  logic [dhkt_pkg::SIZE_W-1:0]   i_divisor,
    output logic [dhkt_pkg::SIZE_W-1:0]   o_rem
);

    logic [dhkt_pkg::KEY_W-1:0]  r_sh;
    logic [dhkt_pkg::SIZE_W-1:0] r_rem;
    logic [dhkt_pkg::SIZE_W-1:0] n_rem;

    // DIV_BITS restoring steps on the SIZE_W-bit remainder, most significant bit first.
    always_comb begin
        logic [dhkt_pkg::SIZE_W:0] t;
        n_rem = r_rem;
        for (int j = 0; j < dhkt_pkg::DIV_BITS; j++) begin
            t = {n_rem, r_sh[dhkt_pkg::KEY_W-1-j]};
            if (t >= {1'b0, i_divisor}) begin
                t = t - {1'b0, i_divisor};
            end
            n_rem = t[dhkt_pkg::SIZE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_sh  <= i_dividend;
            r_rem <= '0;
        end else if (i_step) begin
            r_sh  <= r_sh << dhkt_pkg::DIV_BITS;
            r_rem <= n_rem;
        end
    end

    assign o_rem = r_rem;

endmodule

### src/dhkt_dp.sv
// Datapath: size registers, hash remainders, probe walk, slot memory, result register.
module dhkt_dp #(
    parameter int SLOTS  = 1024,
    parameter int TABLES = 4
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  dhkt_pkg::t_cmd                    i_cmd,
    output dhkt_pkg::t_sts                    o_sts,
    input  logic                              i_cfg_we,
    input  logic [dhkt_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [dhkt_pkg::SIZE_W-1:0]       i_cfg_data,
    input  logic                              i_in_action,
    input  logic [1:0]                        i_in_table_number,
    input  logic [dhkt_pkg::KEY_W-1:0]        i_in_key,
    input  logic                              i_out_stall,
    output logic                              o_out_valid,
    output logic [dhkt_pkg::STATUS_W-1:0]     o_out_status,
    output logic [dhkt_pkg::SLOT_W-1:0]       o_out_slot_index
);

    localparam int DEPTH = TABLES * SLOTS;
    localparam int AW    = $clog2(DEPTH);
    localparam int RW    = dhkt_pkg::KEY_W + 1;
    localparam int SW    = dhkt_pkg::SIZE_W;

    logic [SW-1:0]                   r_size [dhkt_pkg::NUM_SIZES];
    logic                            r_act;
    logic [1:0]                      r_tbl;
    logic                            r_tbl_ok;
    logic [dhkt_pkg::KEY_W-1:0]      r_key;
    logic [SW-1:0]                   r_esize;
    logic [dhkt_pkg::DIV_CNT_W-1:0]  r_div_cnt;
    logic [SW-1:0]                   r_h;
    logic [SW-1:0]                   r_step;
    logic [SW-1:0]                   r_k;
    logic [AW-1:0]                   r_clr;
    dhkt_pkg::t_status               r_res_code;
    logic [dhkt_pkg::SLOT_W-1:0]     r_res_slot;
    logic                            r_out_valid;
    dhkt_pkg::t_status               r_out_status;
    logic [dhkt_pkg::SLOT_W-1:0]     r_out_slot;

    logic [SW-1:0]                   n_esize;
    logic [SW-1:0]                   esize_m1;
    logic [SW-1:0]                   rem_a;
    logic [SW-1:0]                   rem_b;
    logic [SW:0]                     sum_h;
    logic [SW-1:0]                   n_h;
    logic [AW+2:0]                   full_addr;
    logic [AW-1:0]                   ram_addr;
    logic [RW-1:0]                   ram_wdata;
    logic [RW-1:0]                   ram_rdata;

    // Effective size of the addressed table: zero acts as one, clamp at the region size.
    always_comb begin
        n_esize = r_size[i_in_table_number];
        if (n_esize == '0) begin
            n_esize = SW'(1);
        end
        if (int'(n_esize) > SLOTS) begin
            n_esize = SW'(SLOTS);
        end
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < dhkt_pkg::NUM_SIZES; i++) begin
                r_size[i] <= SW'(dhkt_pkg::SIZE_RESET);
            end
        end else if (i_cfg_we) begin
            r_size[i_cfg_index] <= i_cfg_data;
        end
    end

    // The divisors come from the size captured with the item; the load cycle only loads the dividend and clears.
    assign esize_m1 = r_esize - SW'(1);

    // Two remainder lanes: key mod size, and ((key >> 5) + 1) mod (size - 1).
    dhkt_rem u_rem_a (
        .i_clk      (i_clk),
        .i_load     (i_cmd.load),
        .i_step     (i_cmd.div_step),
        .i_dividend (i_in_key),
        .i_divisor  (r_esize),
        .o_rem      (rem_a)
    );

    dhkt_rem u_rem_b (
        .i_clk      (i_clk),
        .i_load     (i_cmd.load),
        .i_step     (i_cmd.div_step),
        .i_dividend ((i_in_key >> 5) + dhkt_pkg::KEY_W'(1)),
        .i_divisor  (esize_m1),
        .o_rem      (rem_b)
    );

    // Item capture and hash step counter.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_act     <= i_in_action;
            r_tbl     <= i_in_table_number;
            r_tbl_ok  <= int'(i_in_table_number) < TABLES;
            r_key     <= i_in_key;
            r_esize   <= n_esize;
            r_div_cnt <= '0;
        end else if (i_cmd.div_step) begin
            r_div_cnt <= r_div_cnt + dhkt_pkg::DIV_CNT_W'(1);
        end
    end

    // Next probe: one compare and subtract, as both terms stay below the size.
    assign sum_h = {1'b0, r_h} + {1'b0, r_step};
    assign n_h   = (sum_h >= {1'b0, r_esize}) ? SW'(sum_h - {1'b0, r_esize})
                                              : sum_h[SW-1:0];

    // Probe walk.
    always_ff @(posedge i_clk) begin
        if (i_cmd.probe_init) begin
            r_h    <= rem_a;
            r_step <= (r_esize == SW'(1)) ? '0 : rem_b + SW'(1);
            r_k    <= '0;
        end else if (i_cmd.advance) begin
            r_h <= n_h;
            r_k <= r_k + SW'(1);
        end
    end

    // Clearing pass counter after reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr <= '0;
        end else if (i_cmd.clr_step) begin
            r_clr <= r_clr + AW'(1);
        end
    end

    // Slot memory: valid bit above the stored key.
    assign full_addr = (AW+3)'(r_tbl) * (AW+3)'(SLOTS) + (AW+3)'(r_h);
    assign ram_addr  = i_cmd.clr_step ? r_clr : full_addr[AW-1:0];
    assign ram_wdata = i_cmd.clr_step ? '0 : {1'b1, r_key};

    dhkt_ram #(
        .WIDTH (RW),
        .DEPTH (DEPTH)
    ) u_slots (
        .i_clk   (i_clk),
        .i_we    (i_cmd.clr_step | i_cmd.wr),
        .i_re    (i_cmd.rd),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (ram_rdata)
    );

    // Result held until the output register is free.
    always_ff @(posedge i_clk) begin
        if (i_cmd.res_set) begin
            r_res_code <= i_cmd.res_code;
            r_res_slot <= i_cmd.res_slot ? r_h[dhkt_pkg::SLOT_W-1:0] : '0;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_status <= r_res_code;
            r_out_slot   <= r_res_slot;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_out_status     = r_out_status;
    assign o_out_slot_index = r_out_slot;

    // Status towards the controller.
    assign o_sts.clr_last   = r_clr == AW'(DEPTH - 1);
    assign o_sts.div_last   = r_div_cnt == dhkt_pkg::DIV_CNT_W'(dhkt_pkg::DIV_STEPS - 1);
    assign o_sts.tbl_ok     = r_tbl_ok;
    assign o_sts.act        = r_act;
    assign o_sts.hit        = ram_rdata[RW-1] && (ram_rdata[RW-2:0] == r_key);
    assign o_sts.empty      = !ram_rdata[RW-1];
    assign o_sts.last_probe = r_k == r_esize - SW'(1);
    assign o_sts.out_free   = !r_out_valid || !i_out_stall;

endmodule

### src/dhkt_ctrl.sv
// Controller state machine: clearing pass, hashing, probing and result hand-off.
module dhkt_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  dhkt_pkg::t_sts i_sts,
    output dhkt_pkg::t_cmd o_cmd
);

    typedef enum logic [6:0] {
        S_CLEAR = 7'b0000001,
        S_IDLE  = 7'b0000010,
        S_HASH  = 7'b0000100,
        S_INIT  = 7'b0001000,
        S_READ  = 7'b0010000,
        S_CHECK = 7'b0100000,
        S_DONE  = 7'b1000000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands.
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_stall = 1'b1;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_HASH;
                end
            end
            S_HASH: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) begin
                    n_state = S_INIT;
                end
            end
            S_INIT: begin
                if (i_sts.tbl_ok) begin
                    o_cmd.probe_init = 1'b1;
                    n_state          = S_READ;
                end else begin
                    o_cmd.res_set  = 1'b1;
                    o_cmd.res_code = (i_sts.act == dhkt_pkg::ACT_INSERT)
                                     ? dhkt_pkg::ST_FULL : dhkt_pkg::ST_NOT_FOUND;
                    n_state        = S_DONE;
                end
            end
            S_READ: begin
                o_cmd.rd = 1'b1;
                n_state  = S_CHECK;
            end
            S_CHECK: begin
                // A find stops on a match or on the last probe; an insert also stops on an empty slot.
                if (i_sts.act == dhkt_pkg::ACT_INSERT && i_sts.empty) begin
                    o_cmd.wr       = 1'b1;
                    o_cmd.res_set  = 1'b1;
                    o_cmd.res_slot = 1'b1;
                    o_cmd.res_code = dhkt_pkg::ST_INSERTED;
                    n_state        = S_DONE;
                end else if (i_sts.hit) begin
                    o_cmd.res_set  = 1'b1;
                    o_cmd.res_slot = 1'b1;
                    o_cmd.res_code = (i_sts.act == dhkt_pkg::ACT_INSERT)
                                     ? dhkt_pkg::ST_PRESENT : dhkt_pkg::ST_FOUND;
                    n_state        = S_DONE;
                end else if (i_sts.last_probe) begin
                    o_cmd.res_set  = 1'b1;
                    o_cmd.res_code = (i_sts.act == dhkt_pkg::ACT_INSERT)
                                     ? dhkt_pkg::ST_FULL : dhkt_pkg::ST_NOT_FOUND;
                    n_state        = S_DONE;
                end else begin
                    o_cmd.advance = 1'b1;
                    n_state       = S_READ;
                end
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

endmodule

### src/double_hash_key_table.sv
// Top level of the double hashing key table.
// After reset the block runs a clearing pass over all TABLES*SLOTS words of the
// slot memory and takes no item meanwhile; size writes are accepted throughout.
// An item is then accepted, hashed in the two remainder lanes (four key bits
// per cycle for both hash terms), set up for the probe walk, probed with a
// read and a check per slot on the single-port slot memory, and handed to the
// output register; each item visits at most size probes.
// A result still stalled in the output register holds the finished item back
// until the stall ends. Items are handled one at a time; a result waiting in
// the output register does not stop the next item from being accepted.
module double_hash_key_table #(
    parameter int SLOTS  = 1024,
    parameter int TABLES = 4
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [dhkt_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [dhkt_pkg::SIZE_W-1:0]       i_cfg_data,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic                              i_in_action,
    input  logic [1:0]                        i_in_table_number,
    input  logic [dhkt_pkg::KEY_W-1:0]        i_in_key,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [dhkt_pkg::STATUS_W-1:0]     o_out_status,
    output logic [dhkt_pkg::SLOT_W-1:0]       o_out_slot_index
);

    dhkt_pkg::t_cmd cmd;
    dhkt_pkg::t_sts sts;

    dhkt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    dhkt_dp #(
        .SLOTS  (SLOTS),
        .TABLES (TABLES)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_sts             (sts),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_in_action       (i_in_action),
        .i_in_table_number (i_in_table_number),
        .i_in_key          (i_in_key),
        .i_out_stall       (i_out_stall),
        .o_out_valid       (o_out_valid),
        .o_out_status      (o_out_status),
        .o_out_slot_index  (o_out_slot_index)
    );

endmodule

### src/dhkt_checker.sv
// Port-level checks of the key table, bound to the top level.
module dhkt_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          o_in_stall,
    input logic                          o_out_valid,
    input logic                          i_out_stall,
    input logic [dhkt_pkg::STATUS_W-1:0] o_out_status,
    input logic [dhkt_pkg::SLOT_W-1:0]   o_out_slot_index
);

    // A stalled result holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_status)
                                       && $stable(o_out_slot_index))
        else $error("stalled result changed");

    // Only defined status codes leave the block.
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_status <= dhkt_pkg::ST_FULL)
        else $error("undefined status code");

    // No slot is reported when the key was not found or the table was full.
    a_no_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_status == dhkt_pkg::ST_NOT_FOUND
                        || o_out_status == dhkt_pkg::ST_FULL)
        |-> o_out_slot_index == '0)
        else $error("slot reported without a slot");

    // One item at a time: the input stalls right after an item is taken.
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("second item taken while busy");

endmodule

bind double_hash_key_table dhkt_checker u_dhkt_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_valid       (i_in_valid),
    .o_in_stall       (o_in_stall),
    .o_out_valid      (o_out_valid),
    .i_out_stall      (i_out_stall),
    .o_out_status     (o_out_status),
    .o_out_slot_index (o_out_slot_index)
);
